@@ hdl/stt_pkg.sv @@
// shared types and constants of the software timer table
`timescale 1ns / 1ps
package stt_pkg;

  localparam int unsigned NumTimersDef = 16;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned TimeW = 48;
  localparam int unsigned DlyW  = 32;
  localparam int unsigned IdW   = 32;
  localparam int unsigned DlW   = 49;
  localparam int unsigned KindW = 2;

  localparam logic [CmdW-1:0] CmdOnce    = 3'd0;
  localparam logic [CmdW-1:0] CmdEvery   = 3'd1;
  localparam logic [CmdW-1:0] CmdUnsched = 3'd2;
  localparam logic [CmdW-1:0] CmdTick    = 3'd3;
  localparam logic [CmdW-1:0] CmdClear   = 3'd4;

  localparam logic [KindW-1:0] KindAssigned = 2'd0;
  localparam logic [KindW-1:0] KindFired    = 2'd1;
  localparam logic [KindW-1:0] KindFull     = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] ident;
    logic [DlW-1:0] deadline;
    logic [DlyW-1:0] period;
  } slot_t;

endpackage

@@ hdl/stt_cmd_if.sv @@
// command channel of the software timer table
`timescale 1ns / 1ps
interface stt_cmd_if
  import stt_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [TimeW-1:0] now_ms;
  logic [DlyW-1:0]  delay_ms;
  logic [IdW-1:0]   timer_id;

  modport source (output valid, output command, output now_ms, output delay_ms,
                  output timer_id, input ready);
  modport sink (input valid, input command, input now_ms, input delay_ms,
                input timer_id, output ready);
endinterface

@@ hdl/stt_res_if.sv @@
// result channel of the software timer table
`timescale 1ns / 1ps
interface stt_res_if
  import stt_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [IdW-1:0]   result_id;
  logic             last;

  modport source (output valid, output kind, output result_id, output last, input ready);
  modport sink (input valid, input kind, input result_id, input last, output ready);
endinterface

@@ hdl/software_timer_table.sv @@
// the schedule or tick beat with last set is registered in the finish state, after the full
//   slot chain rotation; a schedule, unschedule or tick is accepted only in idle, so a new
//   command waits for the rotation and the finish state of the previous one
// clear, unused commands and unschedule above the last issued id need no rotation
// result stalls hold the rotation
// reset: all slots invalid, identifier counter zero, output empty
`timescale 1ns / 1ps
module software_timer_table
  import stt_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NumTimersDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  stt_cmd_if.sink    cmd_i,
  stt_res_if.source  res_o
);

  localparam int unsigned CntW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(NUM_TIMERS - 1);

  state_e state_q, state_d;

  logic [CmdW-1:0]  cmd_q;
  logic [TimeW-1:0] now_q;
  logic [DlyW-1:0]  delay_q;
  logic [IdW-1:0]   tid_q;
  logic [CntW-1:0]  cnt_q;
  logic             found_q;
  logic             pend_q;
  logic [IdW-1:0]   pend_id_q;
  logic [IdW-1:0]   last_id_q;

  logic             out_valid_q;
  logic [KindW-1:0] out_kind_q;
  logic [IdW-1:0]   out_id_q;
  logic             out_last_q;

  logic             in_acc;
  logic             can_push;
  logic             push;
  logic [KindW-1:0] push_kind;
  logic [IdW-1:0]   push_id;
  logic             push_last;
  logic             shift;
  logic             clr;
  logic             id_upd;

  logic [IdW-1:0]   id_inc;
  logic [IdW-1:0]   new_id;
  logic [DlyW-1:0]  add_op;
  logic [DlW-1:0]   sum;
  logic             due;
  logic             fire;
  logic             claim;
  slot_t            head;
  slot_t            wb;
  slot_t            ring [NUM_TIMERS];

  assign in_acc    = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == StIdle);
  assign can_push  = !out_valid_q || res_o.ready;
  assign clr       = in_acc && (cmd_i.command == CmdClear);

  assign id_inc = last_id_q + 32'd1;
  assign new_id = (id_inc == '0) ? 32'd1 : id_inc;

  // slot chain, head at cell 0, write-back enters at the tail
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    slot_t rec_in;
    if (g == NUM_TIMERS - 1) begin : g_tail
      assign rec_in = wb;
    end else begin : g_mid
      assign rec_in = ring[g+1];
    end
    stt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .clr_i  (clr),
      .rec_i  (rec_in),
      .rec_o  (ring[g])
    );
  end

  assign head   = ring[0];
  assign add_op = (cmd_q == CmdTick) ? head.period : delay_q;
  assign sum    = {1'b0, now_q} + {{(DlW - DlyW){1'b0}}, add_op};
  assign due    = head.valid && ({1'b0, now_q} > head.deadline);

  always_comb begin
    wb    = head;
    fire  = 1'b0;
    claim = 1'b0;
    case (cmd_q)
      CmdOnce, CmdEvery: begin
        if (!found_q && !head.valid) begin
          claim       = 1'b1;
          wb.valid    = 1'b1;
          wb.ident    = new_id;
          wb.deadline = sum;
          wb.period   = (cmd_q == CmdEvery) ? delay_q : '0;
        end
      end
      CmdUnsched: begin
        if (!found_q && head.valid && (head.ident == tid_q)) begin
          claim    = 1'b1;
          wb.valid = 1'b0;
        end
      end
      CmdTick: begin
        if (due) begin
          fire = 1'b1;
          if (head.period == '0) begin
            wb.valid = 1'b0;
          end else begin
            wb.deadline = sum;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    push      = 1'b0;
    push_kind = KindFired;
    push_id   = pend_id_q;
    push_last = 1'b0;
    shift     = 1'b0;
    id_upd    = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (cmd_i.command)
            CmdOnce, CmdEvery, CmdTick: state_d = StScan;
            CmdUnsched: begin
              if (cmd_i.timer_id <= last_id_q) begin
                state_d = StScan;
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StScan: begin
        shift = !(fire && pend_q && !can_push);
        push  = shift && fire && pend_q;
        if (shift && (cnt_q == CntLast)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        case (cmd_q)
          CmdOnce, CmdEvery: begin
            push_kind = found_q ? KindAssigned : KindFull;
            push_id   = found_q ? new_id : '0;
            push_last = 1'b1;
            push      = can_push;
            id_upd    = can_push && found_q;
            if (can_push) begin
              state_d = StIdle;
            end
          end
          CmdTick: begin
            push_last = 1'b1;
            push      = pend_q && can_push;
            if (!pend_q || can_push) begin
              state_d = StIdle;
            end
          end
          default: state_d = StIdle;
        endcase
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      last_id_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
        pend_q  <= 1'b0;
      end else if (shift) begin
        cnt_q <= (cnt_q == CntLast) ? '0 : cnt_q + 1'b1;
        if (claim) begin
          found_q <= 1'b1;
        end
        if (fire) begin
          pend_q <= 1'b1;
        end
      end
      if (id_upd) begin
        last_id_q <= new_id;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_i.command;
      now_q   <= cmd_i.now_ms;
      delay_q <= cmd_i.delay_ms;
      tid_q   <= cmd_i.timer_id;
    end
    if (shift && fire) begin
      pend_id_q <= head.ident;
    end
    if (push) begin
      out_kind_q <= push_kind;
      out_id_q   <= push_id;
      out_last_q <= push_last;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.kind      = out_kind_q;
  assign res_o.result_id = out_id_q;
  assign res_o.last      = out_last_q;

`ifndef SYNTHESIS
  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (cnt_q == '0))
    else $error("scan counter not at zero while idle");

  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_id_q != $past(last_id_q)) |-> (last_id_q != '0))
    else $error("identifier counter issued zero");

  a_full_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KindFull)) |-> (out_id_q == '0) && out_last_q)
    else $error("table full beat with nonzero id or without last");

  a_no_push_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |-> !push)
    else $error("result overwritten while stalled");
`endif

endmodule

@@ hdl/stt_cell.sv @@
// one timer slot of the rotating slot chain
`timescale 1ns / 1ps
module stt_cell
  import stt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  logic  clr_i,
  input  slot_t rec_i,
  output slot_t rec_o
);

  logic  valid_q;
  slot_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= rec_i;
    end
  end

  always_comb begin
    rec_o       = data_q;
    rec_o.valid = valid_q;
  end

endmodule

@@ verif/stt_timer_checker.sv @@
// checker of the software timer table: predicts result beats and compares them
`timescale 1ns / 1ps
module stt_timer_checker
  import stt_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NumTimersDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  stt_cmd_if   cmd_i,
  stt_res_if   res_i,
  output int   fail_cnt_o,
  output int   pending_cnt_o
);

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   ident;
    logic             last;
  } timer_beat_t;

  logic            armed    [NUM_TIMERS];
  logic [IdW-1:0]  slot_id  [NUM_TIMERS];
  logic [DlW-1:0]  due_at   [NUM_TIMERS];
  logic [DlyW-1:0] every_ms [NUM_TIMERS];
  logic [IdW-1:0]  newest_id;
  timer_beat_t     beats_due[$];
  int              err_total = 0;

  function automatic void queue_beat(input timer_beat_t b);
    beats_due.insert(beats_due.size(), b);
  endfunction

  task automatic run_command(input logic [CmdW-1:0] op, input logic [TimeW-1:0] now,
                             input logic [DlyW-1:0] dly, input logic [IdW-1:0] tid);
    int             i;
    int             slot;
    int             fired;
    logic [IdW-1:0] fresh;
    timer_beat_t    tail;
    slot  = -1;
    fired = 0;
    case (op)
      CmdOnce, CmdEvery: begin
        for (i = 0; i < NUM_TIMERS; i++) begin
          if (!armed[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          queue_beat(timer_beat_t'{kind: KindFull, ident: '0, last: 1'b1});
        end else begin
          fresh = newest_id + 1'b1;
          if (fresh == '0) fresh = IdW'(1);
          newest_id      = fresh;
          armed[slot]    = 1'b1;
          slot_id[slot]  = fresh;
          due_at[slot]   = {1'b0, now} + DlW'(dly);
          every_ms[slot] = (op == CmdEvery) ? dly : '0;
          queue_beat(timer_beat_t'{kind: KindAssigned, ident: fresh, last: 1'b1});
        end
      end
      CmdUnsched: begin
        if (tid <= newest_id) begin
          for (i = 0; i < NUM_TIMERS; i++) begin
            if (slot < 0 && armed[i] && slot_id[i] == tid) begin
              armed[i] = 1'b0;
              slot     = i;
            end
          end
        end
      end
      CmdTick: begin
        for (i = 0; i < NUM_TIMERS; i++) begin
          if (armed[i] && {1'b0, now} > due_at[i]) begin
            queue_beat(timer_beat_t'{kind: KindFired, ident: slot_id[i], last: 1'b0});
            fired++;
            if (every_ms[i] == '0) armed[i] = 1'b0;
            else due_at[i] = {1'b0, now} + DlW'(every_ms[i]);
          end
        end
        if (fired > 0) begin
          tail      = beats_due.pop_back();
          tail.last = 1'b1;
          queue_beat(tail);
        end
      end
      CmdClear: begin
        for (i = 0; i < NUM_TIMERS; i++) armed[i] = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    timer_beat_t got;
    timer_beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) armed[i] = 1'b0;
      newest_id = '0;
      beats_due.delete();
    end else begin
      if (cmd_i.valid && cmd_i.ready) begin
        run_command(cmd_i.command, cmd_i.now_ms, cmd_i.delay_ms, cmd_i.timer_id);
      end
      if (res_i.valid && res_i.ready) begin
        got = timer_beat_t'{kind: res_i.kind, ident: res_i.result_id, last: res_i.last};
        if (beats_due.size() == 0) begin
          if (err_total < 10) begin
            $display("%0t: unexpected beat kind %0d id %0d last %0b", $time, got.kind,
                     got.ident, got.last);
          end
          err_total++;
        end else begin
          want = beats_due.pop_front();
          if (got !== want) begin
            if (err_total < 10) begin
              $display("%0t: expected kind %0d id %0d last %0b, got kind %0d id %0d last %0b",
                       $time, want.kind, want.ident, want.last, got.kind, got.ident, got.last);
            end
            err_total++;
          end
        end
      end
    end
    fail_cnt_o    <= err_total;
    pending_cnt_o <= beats_due.size();
  end

endmodule

@@ verif/tb_software_timer_table.sv @@
// testbench top of the software timer table: stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module tb_software_timer_table
  import stt_pkg::*;
();

  localparam int unsigned NTimers    = 16;
  localparam int          HoldCycles = 400;
  localparam int          WatchLimit = 4000;
  localparam int          ItemTarget = 230;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic stall_req = 1'b0;

  int              fail_cnt;
  int              pending_cnt;
  int              item_cnt  = 0;
  int unsigned     issued_n  = 0;
  int              calm_left = 0;
  int              idle_cycles = 0;
  logic [TimeW-1:0] cur_time = '0;

  stt_cmd_if cmd_bus ();
  stt_res_if res_bus ();

  software_timer_table #(
    .NUM_TIMERS(NTimers)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .res_o (res_bus)
  );

  stt_timer_checker #(
    .NUM_TIMERS(NTimers)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_bus),
    .res_i        (res_bus),
    .fail_cnt_o   (fail_cnt),
    .pending_cnt_o(pending_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && !(cmd_bus.valid && cmd_bus.ready) && !(res_bus.valid && res_bus.ready)) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int run_left;
    int r;
    bit stall_done;
    run_left      = 0;
    stall_done    = 1'b0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_req && !stall_done) begin
        stall_done    = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (run_left > 0) begin
        run_left--;
        res_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          run_left = $urandom_range(20, 60);
          res_bus.ready <= 1'b1;
        end else if (r < 60) begin
          res_bus.ready <= 1'b1;
        end else if (r < 95) begin
          res_bus.ready <= 1'b0;
        end else begin
          res_bus.ready <= 1'b0;
          repeat ($urandom_range(10, 30)) @(posedge clk_i);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      calm_left = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic offer(input logic [CmdW-1:0] op, input logic [TimeW-1:0] now,
                       input logic [DlyW-1:0] dly, input logic [IdW-1:0] tid);
    cmd_bus.command  <= op;
    cmd_bus.now_ms   <= now;
    cmd_bus.delay_ms <= dly;
    cmd_bus.timer_id <= tid;
    cmd_bus.valid    <= 1'b1;
    do @(posedge clk_i); while (!cmd_bus.ready);
    if (op <= CmdClear) item_cnt++;
    if (op == CmdOnce || op == CmdEvery) issued_n++;
  endtask

  task automatic issue(input logic [CmdW-1:0] op, input logic [TimeW-1:0] now,
                       input logic [DlyW-1:0] dly, input logic [IdW-1:0] tid);
    int gap;
    offer(op, now, dly, tid);
    gap = pick_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (NTimers + 4) @(posedge clk_i);
  endtask

  task automatic random_item();
    int               r;
    int               s;
    logic [CmdW-1:0]  op;
    logic [TimeW-1:0] now;
    logic [DlyW-1:0]  dly;
    logic [IdW-1:0]   tid;
    r   = $urandom_range(0, 99);
    dly = $urandom;
    tid = $urandom;
    if (r < 36) begin
      op = $urandom_range(0, 1) ? CmdEvery : CmdOnce;
      s  = $urandom_range(0, 9);
      if (s < 7) dly = $urandom_range(0, 60);
      else if (s < 8) dly = '0;
    end else if (r < 70) begin
      cur_time = cur_time + TimeW'($urandom_range(0, 40));
      op       = CmdTick;
    end else if (r < 84) begin
      op = CmdUnsched;
      if ($urandom_range(0, 3) != 0) tid = $urandom_range(0, issued_n + 2);
    end else if (r < 90) begin
      op = CmdClear;
    end else if (r < 95) begin
      op = CmdClear + CmdW'($urandom_range(1, 3));
    end else begin
      // time jump, forward or back
      if ($urandom_range(0, 1)) cur_time = {16'($urandom), 32'($urandom)};
      else cur_time = TimeW'($urandom_range(0, 1000));
      op = CmdTick;
    end
    now = cur_time;
    issue(op, now, dly, tid);
  endtask

  initial begin
    logic [TimeW-1:0] tmax;
    tmax             = {TimeW{1'b1}};
    rst_ni           = 1'b0;
    cmd_bus.valid    = 1'b0;
    cmd_bus.command  = CmdOnce;
    cmd_bus.now_ms   = '0;
    cmd_bus.delay_ms = '0;
    cmd_bus.timer_id = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    issue(CmdTick, '0, '1, '1);
    issue(CmdUnsched, 48'd7, '0, 32'd5);
    issue(CmdOnce, 48'd100, '0, '0);
    issue(CmdEvery, 48'd100, '0, '1);
    issue(CmdEvery, 48'd100, 32'd10, '0);
    issue(CmdOnce, 48'd100, '1, '0);
    issue(CmdTick, 48'd100, '0, '0);
    issue(CmdTick, 48'd101, '0, '0);
    issue(CmdTick, 48'd111, '0, '0);
    issue(CmdTick, 48'd122, '0, '0);
    issue(CmdUnsched, 48'd122, '0, 32'd3);
    issue(CmdTick, 48'd200, '0, '0);
    issue(CmdUnsched, 48'd200, '0, 32'd1);
    issue(CmdUnsched, 48'd200, '0, '0);
    issue(CmdUnsched, 48'd200, '0, '1);
    issue(CmdClear + 3'd1, tmax, '1, '1);
    issue(CmdClear + 3'd2, tmax, '1, '1);
    issue(CmdClear + 3'd3, tmax, '1, '1);
    issue(CmdEvery, tmax, '1, '0);
    issue(CmdOnce, tmax - 48'd5, 32'd2, '0);
    issue(CmdTick, tmax, '0, '0);
    issue(CmdClear, tmax, '0, '0);
    issue(CmdTick, tmax, '0, '0);

    // random part, with one long result stall and a burst that fills the table
    while (item_cnt < ItemTarget) begin
      if (item_cnt == 110) begin
        settle();
        stall_req <= 1'b1;
        offer(CmdClear, cur_time, '0, '0);
        for (int k = 0; k < NTimers + 4; k++) begin
          offer(CmdEvery, cur_time, DlyW'(1000 + k), $urandom);
        end
      end
      random_item();
    end

    settle();
    repeat (NTimers + 8) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
